// File: src/rprop_weight_update_defines.svh
// ----------------------------------------------------------------------------
// rprop_weight_update assertion macros
// shared property shapes for the checker of the weight update block
// ----------------------------------------------------------------------------
`ifndef RPROP_WEIGHT_UPDATE_DEFINES_SVH
`define RPROP_WEIGHT_UPDATE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define RWU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is held
`define RWU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// next-cycle implication that also covers the reset period
`define RWU_ASSERT_RAW(label, clk, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rwu_pkg.sv
// ----------------------------------------------------------------------------
// rwu_pkg
// types, register codes and constants of the rprop weight update block
// ----------------------------------------------------------------------------
`default_nettype none

package rwu_pkg;

	localparam int NUM_WEIGHTS_DEF = 1024;

	localparam int INDEX_W  = 10;
	localparam int DATA_W   = 32;
	localparam int FACTOR_W = 16;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GROWTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT    = 3'd4;

	// register reset values
	localparam logic [FACTOR_W-1:0] GROWTH_RST  = 16'd19661;
	localparam logic [FACTOR_W-1:0] SHRINK_RST  = 16'd8192;
	localparam logic [DATA_W-1:0]   CEILING_RST = 32'd3276800;
	localparam logic [DATA_W-1:0]   FLOOR_RST   = 32'd1;
	localparam logic [DATA_W-1:0]   INIT_RST    = 32'd6554;

	// stored gradient sign codes
	localparam logic [1:0] SIGN_NONE = 2'd0;
	localparam logic [1:0] SIGN_POS  = 2'd1;
	localparam logic [1:0] SIGN_NEG  = 2'd2;

	// factors are Q2.14
	localparam int FRAC_SHIFT = 14;
	localparam int PROD_W     = DATA_W + FACTOR_W;

	typedef struct packed {
		logic [FACTOR_W-1:0] growth;
		logic [FACTOR_W-1:0] shrink;
		logic [DATA_W-1:0]   ceiling;
		logic [DATA_W-1:0]   floor_step;
		logic [DATA_W-1:0]   init_step;
	} cfg_t;

	// one entry of the per-weight state memory
	typedef struct packed {
		logic              seen;
		logic [1:0]        sign;
		logic [DATA_W-1:0] step;
	} state_rec_t;

	// outcome of the step rule for one word
	typedef struct packed {
		logic [DATA_W-1:0] step;
		logic [1:0]        sign;
		logic              move;
	} step_res_t;

endpackage

`default_nettype wire

// File: src/rprop_weight_update.sv
// ----------------------------------------------------------------------------
// rprop_weight_update
// irprop- weight update, one gradient word per cycle
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low (weight index, gradient and
// current weight, the last two Q16.16) and returns one word per input in the
// same order through stage one, stage two and the output register. Sustained
// rate is one word per clock while the output is not stalled; it is set by
// the per-weight read-modify-write loop through the state memory, which reads
// at acceptance and writes when a word leaves stage one, with one forwarding
// register covering back-to-back hits on one index. After reset the block
// sweeps the state memory clear, holding in_stall high; configuration writes
// are taken at any time but should only be issued while no word is in flight.
`default_nettype none

module rprop_weight_update import rwu_pkg::*; #(
	parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	// configuration write port
	input  wire                      cfg_we,
	input  wire [CFG_IDX_W-1:0]      cfg_index,
	input  wire [DATA_W-1:0]         cfg_data,
	// input words
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire [INDEX_W-1:0]        weight_index,
	input  wire signed [DATA_W-1:0]  gradient,
	input  wire signed [DATA_W-1:0]  weight_value,
	// result words
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic signed [DATA_W-1:0] new_weight,
	output logic [DATA_W-1:0]        step_now
);

	localparam int ADDR_W    = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
	localparam int IDX_EXT_W = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(NUM_WEIGHTS - 1);

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.growth     <= GROWTH_RST;
			cfg_q.shrink     <= SHRINK_RST;
			cfg_q.ceiling    <= CEILING_RST;
			cfg_q.floor_step <= FLOOR_RST;
			cfg_q.init_step  <= INIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GROWTH:  cfg_q.growth     <= cfg_data[FACTOR_W-1:0];
				REG_SHRINK:  cfg_q.shrink     <= cfg_data[FACTOR_W-1:0];
				REG_CEILING: cfg_q.ceiling    <= cfg_data;
				REG_FLOOR:   cfg_q.floor_step <= cfg_data;
				REG_INIT:    cfg_q.init_step  <= cfg_data;
				default: ; // unused indexes are ignored
			endcase
		end
	end

	// handshake and stage control
	logic valid_s1, valid_s2, out_valid_q;
	logic clear_q;
	logic out_free, s2_free, s2_adv, s1_free, s1_adv, in_acc;

	assign out_free = !out_valid_q || !out_stall;
	assign s2_adv   = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_adv   = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = clear_q || !s1_free;
	assign in_acc   = in_valid && !in_stall;

	// incoming word address and range check
	logic [IDX_EXT_W-1:0] idx_ext;
	logic [ADDR_W-1:0]    in_addr;
	logic                 in_range;

	assign idx_ext  = IDX_EXT_W'(weight_index);
	assign in_addr  = idx_ext[ADDR_W-1:0];
	assign in_range = 32'(weight_index) < 32'(NUM_WEIGHTS);

	// stage one registers
	logic [ADDR_W-1:0]        addr_s1;
	logic                     in_range_s1;
	logic signed [DATA_W-1:0] grad_s1;
	logic signed [DATA_W-1:0] weight_s1;
	state_rec_t               rd_rec_s1;
	state_rec_t               fwd_rec_s1;
	logic                     fwd_hit_s1;

	state_rec_t cur_rec;
	step_res_t  step_res;
	state_rec_t wr_rec;
	logic       fwd_hit;

	// per-weight state memory, swept clear after reset
	state_rec_t        state_mem_q [NUM_WEIGHTS];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	state_rec_t        mem_wdata;

	assign mem_we    = clear_q || (s1_adv && in_range_s1);
	assign mem_waddr = clear_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clear_q ? '0 : wr_rec;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem_q[mem_waddr] <= mem_wdata;
		end
		if (in_acc) begin
			rd_rec_s1 <= state_mem_q[in_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			if (clr_addr_q == CLR_LAST) begin
				clear_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// the word leaving stage one writes on the same edge the next word reads,
	// so a read of that index would see stale data: take the written record
	assign fwd_hit = s1_adv && in_range_s1 && (addr_s1 == in_addr);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1     <= in_addr;
			in_range_s1 <= in_range;
			grad_s1     <= gradient;
			weight_s1   <= weight_value;
			fwd_hit_s1  <= fwd_hit;
			fwd_rec_s1  <= wr_rec;
		end
	end

	assign cur_rec = fwd_hit_s1 ? fwd_rec_s1 : rd_rec_s1;

	rwu_step_calc u_step_calc (
		.cfg      (cfg_q),
		.rec      (cur_rec),
		.gradient (grad_s1),
		.res      (step_res)
	);

	assign wr_rec = '{seen: 1'b1, sign: step_res.sign, step: step_res.step};

	// stage two: step settled, weight move still to do
	logic signed [DATA_W-1:0] weight_s2;
	logic [DATA_W-1:0]        step_s2;
	logic                     move_s2;
	logic                     neg_s2;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			weight_s2 <= weight_s1;
			step_s2   <= in_range_s1 ? step_res.step : '0;
			move_s2   <= in_range_s1 && step_res.move;
			neg_s2    <= grad_s1[DATA_W-1];
		end
	end

	// weight moves against the gradient, saturated to the signed range
	logic signed [DATA_W+1:0] w_ext;
	logic signed [DATA_W+1:0] st_ext;
	logic signed [DATA_W+1:0] w_sum;
	logic signed [DATA_W-1:0] w_sat;
	logic signed [DATA_W-1:0] w_next;

	always_comb begin
		w_ext  = (DATA_W+2)'(weight_s2);
		st_ext = $signed({2'b00, step_s2});
		w_sum  = neg_s2 ? (w_ext + st_ext) : (w_ext - st_ext);
		priority if (w_sum[DATA_W+1:DATA_W-1] == 3'b000 ||
				w_sum[DATA_W+1:DATA_W-1] == 3'b111) begin
			w_sat = w_sum[DATA_W-1:0];
		end else if (w_sum[DATA_W+1]) begin
			w_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			w_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
		w_next = move_s2 ? w_sat : weight_s2;
	end

	// output register
	logic signed [DATA_W-1:0] new_weight_q;
	logic [DATA_W-1:0]        step_now_q;

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			new_weight_q <= w_next;
			step_now_q   <= step_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign new_weight = new_weight_q;
	assign step_now   = step_now_q;

endmodule

`default_nettype wire

// File: src/rwu_step_calc.sv
// ----------------------------------------------------------------------------
// rwu_step_calc
// step size and sign rule for one weight: grow, shrink or keep the step
// ----------------------------------------------------------------------------
`default_nettype none

module rwu_step_calc import rwu_pkg::*; (
	input  cfg_t                     cfg,
	input  state_rec_t               rec,
	input  logic signed [DATA_W-1:0] gradient,
	output step_res_t                res
);

	logic [1:0]          prev_sign;
	logic [1:0]          cur_sign;
	logic                prev_known;
	logic                same_dir;
	logic                flip_dir;
	logic [DATA_W-1:0]   base_step;
	logic [FACTOR_W-1:0] factor;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     prod_rnd;
	logic [PROD_W-FRAC_SHIFT:0] prod_shr;
	logic [DATA_W-1:0]   scaled;

	always_comb begin
		prev_sign  = rec.seen ? rec.sign : SIGN_NONE;
		prev_known = (prev_sign == SIGN_POS) || (prev_sign == SIGN_NEG);
		priority if (gradient[DATA_W-1]) begin
			cur_sign = SIGN_NEG;
		end else if (gradient == '0) begin
			cur_sign = SIGN_NONE;
		end else begin
			cur_sign = SIGN_POS;
		end
		same_dir  = (cur_sign != SIGN_NONE) && prev_known && (cur_sign == prev_sign);
		flip_dir  = (cur_sign != SIGN_NONE) && prev_known && (cur_sign != prev_sign);
		base_step = rec.seen ? rec.step : cfg.init_step;
		factor    = same_dir ? cfg.growth : cfg.shrink;

		// exact product, round half up, saturate to 32 bits
		prod     = PROD_W'(base_step) * PROD_W'(factor);
		prod_rnd = {1'b0, prod} + (PROD_W+1)'(1 << (FRAC_SHIFT - 1));
		prod_shr = prod_rnd[PROD_W:FRAC_SHIFT];
		scaled   = (|prod_shr[PROD_W-FRAC_SHIFT:DATA_W]) ? '1 : prod_shr[DATA_W-1:0];

		priority if (same_dir) begin
			res.step = (scaled > cfg.ceiling) ? cfg.ceiling : scaled;
			res.sign = cur_sign;
			res.move = 1'b1;
		end else if (flip_dir) begin
			res.step = (scaled < cfg.floor_step) ? cfg.floor_step : scaled;
			res.sign = SIGN_NONE;
			res.move = 1'b0;
		end else begin
			res.step = base_step;
			res.sign = cur_sign;
			res.move = 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: src/rwu_checker.sv
// ----------------------------------------------------------------------------
// rwu_checker
// port-level checks of the rprop weight update block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "rprop_weight_update_defines.svh"

module rwu_checker import rwu_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_stall,
	input wire              out_valid,
	input wire              out_stall,
	input wire [DATA_W-1:0] new_weight,
	input wire [DATA_W-1:0] step_now
);

	localparam int PIPE_DEPTH = 3;

	// words accepted but not yet delivered
	logic [1:0] occ_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_acc && !out_acc) begin
			occ_q <= occ_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	`RWU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result word dropped while stalled")
	`RWU_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(new_weight) && $stable(step_now), "stalled result word changed")
	`RWU_ASSERT_RAW(a_clear_stall, clk, !arst_n, in_stall, "input taken before the state sweep")
	`RWU_ASSERT_NOW(a_no_phantom, clk, arst_n, out_valid, occ_q != 2'd0, "result word without an accepted input")
	`RWU_ASSERT_NOW(a_occ_bound, clk, arst_n, in_acc && !out_acc, 32'(occ_q) < PIPE_DEPTH, "more words in flight than stages")

endmodule

bind rprop_weight_update rwu_checker u_rwu_checker (.*);

`default_nettype wire
